// ===== hdl/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the frame
// deframer with CRC-32 check.
// ----------------------------------------------------------------------------
package fdc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 17;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned STS_W    = 2;

    localparam logic [POS_W-1:0] HDR_BYTES     = 17'd16;
    localparam logic [POS_W-1:0] TRAILER_BYTES = 17'd8;
    localparam logic [POS_W-1:0] CRC_TAIL      = 17'd4;
    localparam logic [POS_W-1:0] CODE_END      = 17'd20;
    localparam logic [POS_W-1:0] MIN_FRAME     = 17'd28;
    localparam logic [POS_W-1:0] LEN_HI_POS    = 17'd14;
    localparam logic [POS_W-1:0] LEN_LO_POS    = 17'd15;
    localparam logic [POS_W-1:0] CODE_HI_POS   = 17'd18;
    localparam logic [POS_W-1:0] CODE_LO_POS   = 17'd19;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 2'd0,
        STS_DEV_ERR   = 2'd1,
        STS_CRC_ERR   = 2'd2,
        STS_SHORT     = 2'd3
    } t_status;

    typedef struct packed {
        logic              has;
        logic              kind;
        logic [BYTE_W-1:0] payload;
        t_status           status;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  size;
    } t_result;

    // reflected CRC-32, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc32_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/fdc_parser.sv =====
// ----------------------------------------------------------------------------
// fdc_parser
// Frame state (position, length, return code, running and received CRC) and
// the per-byte decision logic. State advances on i_en.
// ----------------------------------------------------------------------------
module fdc_parser
    import fdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_res
);

    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [POS_W-1:0]  r_total,  n_total;
    logic [CRC_W-1:0]  r_crc,    n_crc;
    logic [CODE_W-1:0] r_code,   n_code;
    logic [CRC_W-1:0]  r_crc_rx, n_crc_rx;

    logic [POS_W:0] pos_x;
    logic [POS_W:0] total_x;
    logic           crc_en;
    logic           crc_rx_en;
    logic           pay_en;
    logic           frame_end;

    always_comb begin
        if (r_pos == LEN_HI_POS) begin
            n_total = {1'b0, i_byte, 8'h00};
        end else if (r_pos == LEN_LO_POS) begin
            n_total = {1'b0, r_total[15:8], i_byte} + HDR_BYTES;
        end else begin
            n_total = r_total;
        end

        if (r_pos == CODE_HI_POS) begin
            n_code = {i_byte, r_code[7:0]};
        end else if (r_pos == CODE_LO_POS) begin
            n_code = {r_code[15:8], i_byte};
        end else begin
            n_code = r_code;
        end

        pos_x   = {1'b0, r_pos};
        total_x = {1'b0, n_total};

        crc_en    = (r_pos < HDR_BYTES) || ((pos_x + {1'b0, TRAILER_BYTES}) < total_x);
        crc_rx_en = (r_pos >= HDR_BYTES) && (n_total >= MIN_FRAME)
                    && ((pos_x + {1'b0, TRAILER_BYTES}) >= total_x)
                    && ((pos_x + {1'b0, CRC_TAIL}) < total_x);
        pay_en    = (r_pos >= CODE_END)
                    && ((pos_x + {1'b0, TRAILER_BYTES}) < total_x)
                    && (n_code == '0);
        frame_end = (r_pos >= LEN_LO_POS) && ((pos_x + 18'd1) >= total_x);

        n_crc    = crc_en ? crc32_byte(r_crc, i_byte) : r_crc;
        n_crc_rx = crc_rx_en ? {r_crc_rx[23:0], i_byte} : r_crc_rx;
        n_pos    = r_pos + 17'd1;

        o_res = '0;
        if (frame_end) begin
            o_res.has  = 1'b1;
            o_res.kind = KIND_STATUS;
            o_res.code = n_code;
            o_res.size = n_total;
            if (n_total < MIN_FRAME) begin
                o_res.status = STS_SHORT;
            end else if (n_code != '0) begin
                o_res.status = STS_DEV_ERR;
            end else if ((n_crc ^ CRC_INIT) != n_crc_rx) begin
                o_res.status = STS_CRC_ERR;
            end else begin
                o_res.status = STS_OK;
            end
        end else if (pay_en) begin
            o_res.has     = 1'b1;
            o_res.kind    = KIND_PAYLOAD;
            o_res.payload = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_total  <= '0;
            r_crc    <= CRC_INIT;
            r_code   <= '0;
            r_crc_rx <= '0;
        end else if (i_en) begin
            if (frame_end) begin
                r_pos    <= '0;
                r_total  <= '0;
                r_crc    <= CRC_INIT;
                r_code   <= '0;
                r_crc_rx <= '0;
            end else begin
                r_pos    <= n_pos;
                r_total  <= n_total;
                r_crc    <= n_crc;
                r_code   <= n_code;
                r_crc_rx <= n_crc_rx;
            end
        end
    end

endmodule

// ===== hdl/frame_deframer_crc32_check.sv =====
// A byte's result is registered: input register, parser, output register. One
// byte per cycle unless i_stall stalls; CRC-32 update and counters share a cycle.
// A byte yields at most one transaction: a payload byte or an end-of-frame status.
// Reset (i_rst_n, synchronous, active low) empties both registers and returns the
// parser to the start of a header with the CRC preset to all ones.
// ----------------------------------------------------------------------------
// frame_deframer_crc32_check
// Length-prefixed frame parser with CRC-32 check: input register, parser,
// output register.
// ----------------------------------------------------------------------------
module frame_deframer_crc32_check
    import fdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_out_kind,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [STS_W-1:0]  o_frame_status,
    output logic [CODE_W-1:0] o_device_code,
    output logic [POS_W-1:0]  o_frame_size
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           parse_res;
    logic              out_free;
    logic              advance;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    fdc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_res   (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && parse_res.has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= parse_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_kind     = r_out.kind;
    assign o_payload_byte = r_out.payload;
    assign o_frame_status = r_out.status;
    assign o_device_code  = r_out.code;
    assign o_frame_size   = r_out.size;

endmodule

// ===== hdl/fdc_checker.sv =====
// ----------------------------------------------------------------------------
// fdc_checker
// Port-level checks on the deframer's result transactions.
// ----------------------------------------------------------------------------
module fdc_checker
    import fdc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_out_kind,
    input logic [BYTE_W-1:0] o_payload_byte,
    input logic [STS_W-1:0]  o_frame_status,
    input logic [CODE_W-1:0] o_device_code,
    input logic [POS_W-1:0]  o_frame_size
);

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_PAYLOAD) |->
            (o_frame_status == STS_OK) && (o_device_code == '0) && (o_frame_size == '0))
        else $error("payload transaction carries status fields");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_STATUS) |->
            (o_payload_byte == '0) && (o_frame_size >= HDR_BYTES))
        else $error("status transaction malformed");

    a_short_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_STATUS) |->
            ((o_frame_size < MIN_FRAME) == (o_frame_status == STS_SHORT)))
        else $error("short-frame status does not match frame size");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=>
            o_valid && $stable(o_out_kind) && $stable(o_payload_byte)
            && $stable(o_frame_status) && $stable(o_device_code) && $stable(o_frame_size))
        else $error("stalled result changed");

endmodule

bind frame_deframer_crc32_check fdc_checker u_fdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_kind     (o_out_kind),
    .o_payload_byte (o_payload_byte),
    .o_frame_status (o_frame_status),
    .o_device_code  (o_device_code),
    .o_frame_size   (o_frame_size)
);

// ===== verif/fdc_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdc_tb_pkg
// Scoreboard for the frame deframer bench. A byte-level parser model
// predicts the output transactions, and a FIFO of them is matched against
// what the block produces. Holds the bench's own CRC-32 step as well.
// ----------------------------------------------------------------------------
package fdc_tb_pkg;
    import fdc_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload;
        t_status           status;
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  size;
    } t_out_txn;

    // reflected CRC-32, data bits taken LSB first
    function automatic logic [CRC_W-1:0] crc_next(
        input logic [CRC_W-1:0]  c,
        input logic [BYTE_W-1:0] d
    );
        logic [CRC_W-1:0] r;
        r = c;
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[0] ^ d[i]) begin
                r = {1'b0, r[CRC_W-1:1]} ^ CRC_POLY;
            end else begin
                r = {1'b0, r[CRC_W-1:1]};
            end
        end
        return r;
    endfunction

    class deframer_scoreboard;
        int unsigned      byte_idx;
        logic [POS_W-1:0] frame_len;
        logic [CRC_W-1:0] crc_acc;
        logic [CODE_W-1:0] code_seen;
        logic [CRC_W-1:0] crc_seen;

        t_out_txn    outputs_due[$];
        int unsigned errors;
        int unsigned matched;
        int unsigned frames;
        int unsigned payload_bytes;
        int unsigned bytes_in;
        int unsigned longest_frame;
        int unsigned status_seen[4];

        function new();
            clear_frame();
        endfunction

        function void clear_frame();
            byte_idx  = 0;
            frame_len = '0;
            crc_acc   = CRC_INIT;
            code_seen = '0;
            crc_seen  = '0;
        endfunction

        // one accepted byte in, zero or one predicted transaction out
        function void take_byte(input logic [BYTE_W-1:0] b);
            t_out_txn    t;
            int unsigned p;
            p = byte_idx;
            bytes_in++;

            if (p == LEN_HI_POS) begin
                frame_len = {1'b0, b, 8'h00};
            end else if (p == LEN_LO_POS) begin
                frame_len = {1'b0, frame_len[15:8], b} + HDR_BYTES;
            end

            if (p == CODE_HI_POS) begin
                code_seen[15:8] = b;
            end else if (p == CODE_LO_POS) begin
                code_seen[7:0] = b;
            end

            if (p < HDR_BYTES || p + TRAILER_BYTES < frame_len) begin
                crc_acc = crc_next(crc_acc, b);
            end

            if (p >= HDR_BYTES && frame_len >= MIN_FRAME &&
                p + TRAILER_BYTES >= frame_len && p + CRC_TAIL < frame_len) begin
                crc_seen = {crc_seen[23:0], b};
            end

            if (p >= CODE_END && p + TRAILER_BYTES < frame_len && code_seen == '0) begin
                t = '{KIND_PAYLOAD, b, STS_OK, '0, '0};
                outputs_due.push_back(t);
                payload_bytes++;
            end

            if (p >= LEN_LO_POS && p + 1 >= frame_len) begin
                t.kind    = KIND_STATUS;
                t.payload = '0;
                if (frame_len < MIN_FRAME) begin
                    t.status = STS_SHORT;
                end else if (code_seen != '0) begin
                    t.status = STS_DEV_ERR;
                end else if ((crc_acc ^ CRC_INIT) != crc_seen) begin
                    t.status = STS_CRC_ERR;
                end else begin
                    t.status = STS_OK;
                end
                t.code = code_seen;
                t.size = frame_len;
                outputs_due.push_back(t);
                frames++;
                status_seen[t.status]++;
                if (frame_len > longest_frame) begin
                    longest_frame = frame_len;
                end
                clear_frame();
                return;
            end

            byte_idx = p + 1;
        endfunction

        function void match_output(
            input logic              kind,
            input logic [BYTE_W-1:0] payload,
            input logic [STS_W-1:0]  status,
            input logic [CODE_W-1:0] code,
            input logic [POS_W-1:0]  size
        );
            t_out_txn want;
            if (outputs_due.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t unexpected transaction: kind %0d byte %02h sts %0d code %04h size %0d",
                             $realtime, kind, payload, status, code, size);
                end
                return;
            end
            want = outputs_due.pop_front();
            matched++;
            if (kind !== want.kind || payload !== want.payload || status !== want.status ||
                code !== want.code || size !== want.size) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t mismatch on transaction %0d", $realtime, matched);
                    $display("  expected kind %0d byte %02h sts %0d code %04h size %0d",
                             want.kind, want.payload, want.status, want.code, want.size);
                    $display("  actual   kind %0d byte %02h sts %0d code %04h size %0d",
                             kind, payload, status, code, size);
                end
            end
        endfunction

        function int unsigned close_out();
            if (outputs_due.size() != 0) begin
                errors++;
                $display("%0d expected transactions never arrived", outputs_due.size());
            end
            return errors;
        endfunction
    endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_deframer_crc32_check. Builds frames with
// good and corrupted CRCs, short lengths and device errors, streams them
// with random idles and back-pressure, and matches every output
// transaction against the scoreboard's parser model.
// ----------------------------------------------------------------------------
module tb;
    import fdc_pkg::*;
    import fdc_tb_pkg::*;

    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned RANDOM_BYTES = 250;
    localparam int unsigned DRAIN_LIMIT  = 200000;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              i_stall   = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_out_kind;
    logic [BYTE_W-1:0] o_payload_byte;
    logic [STS_W-1:0]  o_frame_status;
    logic [CODE_W-1:0] o_device_code;
    logic [POS_W-1:0]  o_frame_size;

    deframer_scoreboard sb = new();

    bit          tx_burst;
    int unsigned rx_left;
    bit          rx_stalling;
    int unsigned hold_idx;
    int unsigned holds_done;
    int unsigned hold_marks[2] = '{40, 200};

    frame_deframer_crc32_check uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_kind     (o_out_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_status (o_frame_status),
        .o_device_code  (o_device_code),
        .o_frame_size   (o_frame_size)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // called at a clock edge; returns at the edge where the byte was taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_byte(i_rx_byte);
    endtask

    // fill < 0 gives random content
    task automatic send_frame(
        input int unsigned       len,
        input logic [CODE_W-1:0] code,
        input bit                crc_ok,
        input int                fill
    );
        logic [BYTE_W-1:0] fr[$];
        logic [CRC_W-1:0]  c;
        int unsigned       total;
        total = len + HDR_BYTES;
        for (int unsigned i = 0; i < total; i++) begin
            fr.push_back(fill < 0 ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(fill));
        end
        fr[LEN_HI_POS] = len[15:8];
        fr[LEN_LO_POS] = len[7:0];
        if (total > CODE_HI_POS) begin
            fr[CODE_HI_POS] = code[15:8];
        end
        if (total > CODE_LO_POS) begin
            fr[CODE_LO_POS] = code[7:0];
        end
        if (total >= MIN_FRAME) begin
            c = CRC_INIT;
            for (int unsigned i = 0; i + TRAILER_BYTES < total; i++) begin
                c = crc_next(c, fr[i]);
            end
            c = c ^ CRC_INIT;
            if (!crc_ok) begin
                c = c ^ (32'h1 << $urandom_range(0, 31));
            end
            for (int k = 0; k < 4; k++) begin
                fr[total - TRAILER_BYTES + k] = c[31 - 8*k -: 8];
            end
        end
        tx_burst = ($urandom_range(0, 3) == 0);
        foreach (fr[i]) begin
            send_byte(fr[i]);
        end
    endtask

    task automatic random_frame();
        int unsigned       r;
        int unsigned       len;
        logic [CODE_W-1:0] code;
        r    = $urandom_range(0, 99);
        code = CODE_W'($urandom_range(1, 16'hFFFF));
        if (r < 65) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(61, 300) : $urandom_range(12, 60);
            send_frame(len, ($urandom_range(0, 4) == 0) ? code : '0,
                       $urandom_range(0, 9) != 0, -1);
        end else if (r < 85) begin
            send_frame($urandom_range(0, 11), $urandom_range(0, 1) ? code : '0, 1'b1, -1);
        end else begin
            send_frame($urandom_range(12, 40), ($urandom_range(0, 3) == 0) ? code : '0, 1'b0, -1);
        end
    endtask

    // receiver: checks each output transaction and paces i_stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                sb.match_output(o_out_kind, o_payload_byte, o_frame_status,
                                o_device_code, o_frame_size);
            end
            if (hold_idx < 2 && sb.matched >= hold_marks[hold_idx]) begin
                hold_idx++;
                holds_done++;
                rx_left     = LONG_HOLD;
                rx_stalling = 1'b1;
            end
            if (rx_left == 0) begin
                rx_stalling = ($urandom_range(0, 99) < 35);
                if (rx_stalling) begin
                    rx_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
                end else begin
                    rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                          : $urandom_range(1, 8);
                end
            end
            rx_left--;
            i_stall <= rx_stalling;
        end
    end

    initial begin
        int unsigned base;
        int unsigned drain;
        int unsigned errs;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        send_frame(0,        16'h0000, 1'b1, -1);
        send_frame(2,        16'h0000, 1'b1, -1);
        send_frame(3,        16'hAB00, 1'b1, -1);
        send_frame(4,        16'h8001, 1'b1, -1);
        send_frame(11,       16'h1234, 1'b1, -1);
        send_frame(12,       16'h0000, 1'b1, -1);
        send_frame(13,       16'h0000, 1'b1, 8'h00);
        send_frame(20,       16'h0000, 1'b1, 8'hFF);
        send_frame(20,       16'h0000, 1'b0, -1);
        send_frame(16,       16'hFFFF, 1'b1, -1);
        send_frame(16,       16'h0001, 1'b0, -1);
        send_frame(16'h0100, 16'h0000, 1'b1, -1);

        base = sb.bytes_in;
        while (sb.bytes_in < base + RANDOM_BYTES) begin
            random_frame();
        end
        i_valid <= 1'b0;

        drain = 0;
        while (sb.outputs_due.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (16) @(posedge i_clk);

        errs = sb.close_out();
        $display("Parsed %0d frames from %0d bytes: ok %0d, device error %0d, %s",
                 sb.frames, sb.bytes_in, sb.status_seen[STS_OK], sb.status_seen[STS_DEV_ERR],
                 $sformatf("crc error %0d, short %0d",
                           sb.status_seen[STS_CRC_ERR], sb.status_seen[STS_SHORT]));
        $display("%0d transactions matched (%0d payload bytes), longest frame %0d, %s",
                 sb.matched, sb.payload_bytes, sb.longest_frame,
                 $sformatf("%0d long holds, %0d errors", holds_done, errs));
        if (errs == 0) begin
            $display("PASS frame_deframer_crc32_check");
        end else begin
            $display("FAIL frame_deframer_crc32_check");
        end
        $finish;
    end

    initial begin
        #600_000_000;
        $display("FAIL frame_deframer_crc32_check");
        $finish;
    end

endmodule
